### hw/rtl/irb_pkg.sv
// Shared types and constants for the in-order release buffer.
// Used by irb_ctrl, irb_dp and in_order_release_buffer; depends on nothing.
package irb_pkg;

	localparam int SEQ_W            = 16;
	localparam int HANDLE_W         = 32;
	localparam int WINDOW_SLOTS_DEF = 16;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// register index, taken from paddr[APB_ADDR_W-1:2]
	localparam logic [APB_ADDR_W-1:2] REG_TOTAL_ITEMS = '0;
	localparam logic [SEQ_W-1:0]      TOTAL_RESET     = 16'hFFFF;

	localparam logic STATUS_RELEASED = 1'b0;
	localparam logic STATUS_REJECTED = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_LOOK,
		S_EMIT
	} irb_state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;  // take the input beat
		logic reject;   // load a reject result
		logic store;    // write the held item into its slot
		logic read;     // read the slot handle for the next release
		logic release_; // load a release result and advance
	} irb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic reject;   // held item lies outside window or total
		logic out_free; // output register can take a result
		logic run_go;   // slot at next expected is full and below total
		logic run_more; // the slot after it would continue the run
	} irb_sts_t;

endpackage

### hw/rtl/irb_ctrl.sv
// Controller state machine for the in-order release buffer.
// Depends on irb_pkg; drives irb_dp through irb_cmd_t, watches irb_sts_t.
module irb_ctrl import irb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  irb_sts_t sts,
	output irb_cmd_t cmd
);

	irb_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_CHECK;
			end
			S_CHECK: begin
				if (sts.reject) begin
					if (sts.out_free) state_d = S_IDLE;
				end else begin
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				state_d = sts.run_go ? S_EMIT : S_IDLE;
			end
			S_EMIT: begin
				if (sts.out_free && !sts.run_more) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_CHECK: begin
				cmd.reject = sts.reject && sts.out_free;
				cmd.store  = !sts.reject;
			end
			S_LOOK: begin
				cmd.read = sts.run_go;
			end
			S_EMIT: begin
				cmd.release_ = sts.out_free;
				// fetch the following handle while this one goes out
				cmd.read     = sts.out_free && sts.run_more;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### hw/rtl/irb_dp.sv
// Datapath of the in-order release buffer: held input, slot store, full bits,
// next expected number and output register. Depends on irb_pkg.
module irb_dp import irb_pkg::*; #(
	parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [SEQ_W-1:0]    seq_number,
	input  logic [HANDLE_W-1:0] payload_handle,
	input  logic [SEQ_W-1:0]    total_items,
	input  irb_cmd_t            cmd,
	output irb_sts_t            sts,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [SEQ_W-1:0]    out_seq_number,
	output logic [HANDLE_W-1:0] out_payload_handle,
	output logic                status,
	output logic                run_last,
	output logic                all_done
);

	localparam int IW = $clog2(WINDOW_SLOTS);
	localparam logic [IW-1:0]  LAST_SLOT = IW'(WINDOW_SLOTS - 1);
	localparam logic [IW:0]    SLOTS_X   = (IW+1)'(WINDOW_SLOTS);
	localparam logic [SEQ_W-1:0] SLOTS_S = SEQ_W'(WINDOW_SLOTS);

	logic [SEQ_W-1:0]    seq_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [SEQ_W-1:0]    next_q;
	logic [IW-1:0]       head_q;
	logic [WINDOW_SLOTS-1:0] full_q;
	logic [HANDLE_W-1:0] slot_mem [WINDOW_SLOTS];
	logic [HANDLE_W-1:0] rd_data_q;

	logic                out_valid_q;
	logic [SEQ_W-1:0]    out_seq_q;
	logic [HANDLE_W-1:0] out_handle_q;
	logic                out_status_q;
	logic                out_last_q;
	logic                out_done_q;

	logic [SEQ_W-1:0] diff;
	logic             behind, beyond, over_total;
	logic [IW:0]      slot_sum;
	logic [IW-1:0]    slot_wr;
	logic [IW-1:0]    head_inc;
	logic [IW-1:0]    rd_addr;
	logic [SEQ_W:0]   next_inc;
	logic [SEQ_W:0]   total_x;

	assign diff       = seq_q - next_q;
	assign behind     = seq_q < next_q;
	assign beyond     = diff >= SLOTS_S;
	assign over_total = seq_q >= total_items;

	// slot = head + offset, folded once since offset stays below the window
	assign slot_sum = {1'b0, head_q} + {1'b0, diff[IW-1:0]};
	assign slot_wr  = (slot_sum >= SLOTS_X) ? IW'(slot_sum - SLOTS_X) : slot_sum[IW-1:0];

	assign head_inc = (head_q == LAST_SLOT) ? '0 : head_q + IW'(1);
	assign rd_addr  = cmd.release_ ? head_inc : head_q;
	assign next_inc = {1'b0, next_q} + (SEQ_W+1)'(1);
	assign total_x  = {1'b0, total_items};

	assign sts.reject   = behind || beyond || over_total;
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.run_go   = (next_q < total_items) && full_q[head_q];
	assign sts.run_more = (next_inc < total_x) && full_q[head_inc];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			seq_q    <= seq_number;
			handle_q <= payload_handle;
		end
		if (cmd.store) slot_mem[slot_wr] <= handle_q;
		if (cmd.read)  rd_data_q <= slot_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q <= '0;
			head_q <= '0;
			full_q <= '0;
		end else begin
			if (cmd.store) full_q[slot_wr] <= 1'b1;
			if (cmd.release_) begin
				full_q[head_q] <= 1'b0;
				next_q         <= next_inc[SEQ_W-1:0];
				head_q         <= head_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.reject || cmd.release_) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.reject) begin
			out_seq_q    <= seq_q;
			out_handle_q <= handle_q;
			out_status_q <= STATUS_REJECTED;
			out_last_q   <= 1'b1;
			out_done_q   <= next_q >= total_items;
		end else if (cmd.release_) begin
			out_seq_q    <= next_q;
			out_handle_q <= rd_data_q;
			out_status_q <= STATUS_RELEASED;
			out_last_q   <= !sts.run_more;
			out_done_q   <= next_inc >= total_x;
		end
	end

	assign out_valid          = out_valid_q;
	assign out_seq_number     = out_seq_q;
	assign out_payload_handle = out_handle_q;
	assign status             = out_status_q;
	assign run_last           = out_last_q;
	assign all_done           = out_done_q;

	a_store_release_apart: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.store && cmd.release_))
		else $error("slot write and release in the same cycle");

	a_release_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.release_ |-> full_q[head_q])
		else $error("release from an empty slot");

	a_release_advance: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.release_ |=> next_q == $past(next_q) + SEQ_W'(1))
		else $error("next expected did not advance by one");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= LAST_SLOT)
		else $error("head index outside the window");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !(cmd.reject || cmd.release_))
		else $error("result loaded over one not yet taken");

endmodule

### hw/rtl/in_order_release_buffer.sv
// In-order release buffer: a sequence number tagged item arrives on a slave stream at any
// rate, taken only when idle. Each beat is held, checked and, if in range, stored; then
// the next expected slot is looked up. When the next expected number is stored, the buffer
// releases it and every consecutive follower at one beat per cycle while the master stream
// does not stall, each handle registered before its release. An item behind the expected
// number, beyond the window or at or above total_items gives a single reject beat (tuser
// status bit set). tlast marks the final beat caused by one input and all_done rises once
// the expected number reaches total_items. The user writes total_items over the APB port
// only while the buffer is idle; the block does not enforce it. Slot full bits clear at
// reset; slot handles need no clearing. Top level; depends on irb_pkg, irb_ctrl and irb_dp.
module in_order_release_buffer import irb_pkg::*; #(
	parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// APB configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	// slave stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [47:0]           s_tdata,  // [15:0] seq_number, [47:16] payload_handle
	// master stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [47:0]           m_tdata,  // [15:0] out_seq_number, [47:16] out_payload_handle
	output logic                  m_tlast,  // run_last
	output logic [1:0]            m_tuser   // [0] status, [1] all_done
);

	logic [SEQ_W-1:0] total_q;
	logic             cfg_wr;
	irb_cmd_t         cmd;
	irb_sts_t         sts;
	logic [SEQ_W-1:0]    out_seq;
	logic [HANDLE_W-1:0] out_handle;
	logic                out_status;
	logic                out_done;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[APB_ADDR_W-1:2] == REG_TOTAL_ITEMS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TOTAL_RESET;
		end else if (cfg_wr) begin
			total_q <= pwdata[SEQ_W-1:0];
		end
	end

	assign prdata = (paddr[APB_ADDR_W-1:2] == REG_TOTAL_ITEMS)
		? {{(APB_DATA_W-SEQ_W){1'b0}}, total_q} : '0;

	irb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	irb_dp #(
		.WINDOW_SLOTS (WINDOW_SLOTS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.seq_number         (s_tdata[15:0]),
		.payload_handle     (s_tdata[47:16]),
		.total_items        (total_q),
		.cmd                (cmd),
		.sts                (sts),
		.out_ready          (m_tready),
		.out_valid          (m_tvalid),
		.out_seq_number     (out_seq),
		.out_payload_handle (out_handle),
		.status             (out_status),
		.run_last           (m_tlast),
		.all_done           (out_done)
	);

	assign m_tdata = {out_handle, out_seq};
	assign m_tuser = {out_done, out_status};

endmodule

### tb/irb_release_monitor.sv
// Release monitor for the in-order release buffer: watches the APB port and both streams,
// keeps its own copy of the window, slots and total, and compares every master beat.
// Depends on irb_pkg; instantiated by in_order_release_buffer_tb.
module irb_release_monitor import irb_pkg::*; #(
	parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	input  logic                  pready,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [47:0]           s_tdata,  // [15:0] seq_number, [47:16] payload_handle
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [47:0]           m_tdata,  // [15:0] out_seq_number, [47:16] out_payload_handle
	input  logic                  m_tlast,  // run_last
	input  logic [1:0]            m_tuser,  // [0] status, [1] all_done
	output int                    mismatches,
	output int                    pending,
	output logic [SEQ_W-1:0]      next_seq
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [SEQ_W-1:0]    seq;
		logic [HANDLE_W-1:0] handle;
		logic                status;
		logic                last;
		logic                done;
	} release_beat_t;

	logic [SEQ_W-1:0]    total_items;
	logic [SEQ_W-1:0]    next_expected;
	logic                slot_full [WINDOW_SLOTS];
	logic [HANDLE_W-1:0] slot_handle [WINDOW_SLOTS];
	release_beat_t       expected_beats [$];

	function automatic void predict_release(input logic [SEQ_W-1:0] seq,
	                                        input logic [HANDLE_W-1:0] handle);
		release_beat_t beat;
		int count;
		int idx;
		count = 0;
		if (seq < next_expected || int'(seq) - int'(next_expected) >= WINDOW_SLOTS ||
		    seq >= total_items) begin
			beat.seq    = seq;
			beat.handle = handle;
			beat.status = STATUS_REJECTED;
			beat.last   = 1'b1;
			beat.done   = next_expected >= total_items;
			expected_beats = {expected_beats, beat};
			return;
		end
		idx = int'(seq) % WINDOW_SLOTS;
		slot_full[idx]   = 1'b1;
		slot_handle[idx] = handle;
		// drain the run that continues from the expected number
		while (count < WINDOW_SLOTS && next_expected < total_items &&
		       slot_full[int'(next_expected) % WINDOW_SLOTS]) begin
			idx            = int'(next_expected) % WINDOW_SLOTS;
			slot_full[idx] = 1'b0;
			beat.seq       = next_expected;
			beat.handle    = slot_handle[idx];
			beat.status    = STATUS_RELEASED;
			beat.last      = 1'b0;
			next_expected  = next_expected + 1'b1;
			beat.done      = next_expected >= total_items;
			expected_beats = {expected_beats, beat};
			count++;
		end
		if (count > 0) begin
			beat      = expected_beats.pop_back();
			beat.last = 1'b1;
			expected_beats = {expected_beats, beat};
		end
	endfunction

	function automatic void compare_beat();
		release_beat_t want;
		logic [SEQ_W-1:0]    got_seq;
		logic [HANDLE_W-1:0] got_handle;
		got_seq    = m_tdata[SEQ_W-1:0];
		got_handle = m_tdata[SEQ_W +: HANDLE_W];
		if (expected_beats.size() == 0) begin
			mismatches++;
			$display("%0t: beat with nothing expected: seq %h handle %h status %b last %b done %b",
			         $realtime, got_seq, got_handle, m_tuser[0], m_tlast, m_tuser[1]);
			return;
		end
		want = expected_beats.pop_front();
		if (want.seq !== got_seq || want.handle !== got_handle || want.status !== m_tuser[0] ||
		    want.last !== m_tlast || want.done !== m_tuser[1]) begin
			mismatches++;
			$display("%0t: expected seq %h handle %h status %b last %b done %b", $realtime,
			         want.seq, want.handle, want.status, want.last, want.done);
			$display("%0t:      got seq %h handle %h status %b last %b done %b", $realtime,
			         got_seq, got_handle, m_tuser[0], m_tlast, m_tuser[1]);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_items   = TOTAL_RESET;
			next_expected = '0;
			mismatches    = 0;
			foreach (slot_full[i]) slot_full[i] = 1'b0;
			expected_beats.delete();
		end else begin
			if (m_tvalid && m_tready)
				compare_beat();
			if (psel && penable && pwrite && pready && paddr[APB_ADDR_W-1:2] == REG_TOTAL_ITEMS)
				total_items = pwdata[SEQ_W-1:0];
			if (s_tvalid && s_tready)
				predict_release(s_tdata[SEQ_W-1:0], s_tdata[SEQ_W +: HANDLE_W]);
		end
		pending  = expected_beats.size();
		next_seq = next_expected;
	end

endmodule

### tb/in_order_release_buffer_tb.sv
// Top of the in-order release buffer testbench: clock, reset, APB writes, the slave stream
// sender and the master stream stall pattern. Depends on irb_pkg, in_order_release_buffer
// and irb_release_monitor, which does all the checking.
module in_order_release_buffer_tb import irb_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN         = WINDOW_SLOTS_DEF;
	localparam int CYCLE_LIMIT = 400_000;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [APB_ADDR_W-1:0] paddr    = '0;
	logic [APB_DATA_W-1:0] pwdata   = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [47:0]           s_tdata  = '0;  // [15:0] seq_number, [47:16] payload_handle
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [47:0]           m_tdata;        // [15:0] out_seq_number, [47:16] out_payload_handle
	logic                  m_tlast;        // run_last
	logic [1:0]            m_tuser;        // [0] status, [1] all_done

	int               mismatches;
	int               pending;
	logic [SEQ_W-1:0] next_seq;
	int               burst_left = 0;
	int               cycles     = 0;
	int               rx_cycle   = 0;
	int               rx_mode    = 0;

	in_order_release_buffer #(.WINDOW_SLOTS(WIN)) uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	irb_release_monitor #(.WINDOW_SLOTS(WIN)) release_monitor (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.mismatches(mismatches), .pending(pending), .next_seq(next_seq)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver: switch stall style every so often, including stretches of no stall
	always @(negedge clk) begin
		rx_cycle++;
		if (rx_cycle % 150 == 0)
			rx_mode = $urandom_range(0, 3);
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 1) == 1);
			2: m_tready <= (rx_cycle % 5 < 2);
			default: m_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	task automatic send_item(input logic [SEQ_W-1:0] seq, input logic [HANDLE_W-1:0] handle);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {handle, seq};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
	endtask

	// hold the sender until every expected beat is out and the block has settled
	task automatic hold_until_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_total(input logic [SEQ_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_TOTAL_ITEMS, 2'b00};
		pwdata  <= APB_DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	initial begin
		logic [SEQ_W-1:0] base;
		logic [SEQ_W-1:0] noise;
		logic [SEQ_W-1:0] limit;
		int order [WIN];
		int size;
		int pick;
		int tmp;
		int phase_items;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// in-order, out-of-order and duplicate inserts under the reset total
		send_item(16'd0, 32'h0000_0000);
		send_item(16'd2, $urandom);
		send_item(16'd1, $urandom);
		send_item(16'd4, $urandom);
		send_item(16'd4, $urandom);
		send_item(16'd3, $urandom);
		send_item(16'd0, $urandom);                      // behind expected
		send_item(SEQ_W'(5 + WIN), $urandom);            // just beyond the window
		send_item(SEQ_W'(4 + WIN), $urandom);            // last slot of the window
		send_item(16'hFFFF, 32'hFFFF_FFFF);
		for (int s = 3 + WIN; s >= 6; s--)
			send_item(SEQ_W'(s), $urandom);
		send_item(16'd5, $urandom);                      // releases a full window

		// zero total: everything is rejected as done
		hold_until_drained();
		write_total('0);
		send_item(next_seq, $urandom);
		send_item(16'd0, $urandom);
		send_item(16'hFFFF, 32'hFFFF_FFFF);

		// lower the total under stored items, then raise it and resume
		hold_until_drained();
		write_total(TOTAL_RESET);
		base = next_seq;
		for (int k = 9; k >= 1; k--)
			send_item(base + SEQ_W'(k), $urandom);
		hold_until_drained();
		write_total(base + 16'd4);
		send_item(base, $urandom);
		send_item(base + 16'd5, $urandom);
		hold_until_drained();
		write_total(TOTAL_RESET);
		send_item(base + 16'd10, $urandom);

		for (int phase = 0; phase < 5; phase++) begin
			hold_until_drained();
			base = next_seq;
			case (phase)
				0: limit = TOTAL_RESET;
				1: limit = base + SEQ_W'($urandom_range(40, 90));
				2: limit = SEQ_W'($urandom);
				3: limit = base + SEQ_W'($urandom_range(1, WIN));
				default: limit = TOTAL_RESET;
			endcase
			write_total(limit);
			phase_items = 0;
			while (phase_items < 85) begin
				size = $urandom_range(1, WIN);
				for (int k = 0; k < size; k++)
					order[k] = k;
				for (int k = size - 1; k > 0; k--) begin
					pick = $urandom_range(0, k);
					tmp = order[k];
					order[k] = order[pick];
					order[pick] = tmp;
				end
				for (int k = 0; k < size; k++) begin
					if ($urandom_range(0, 5) == 0) begin
						case ($urandom_range(0, 2))
							0: noise = SEQ_W'($urandom);
							1: noise = (base > 0) ?
							           base - SEQ_W'($urandom_range(1, base < 40 ? base : 40)) :
							           SEQ_W'($urandom);
							default: noise = base + SEQ_W'(order[$urandom_range(0, size - 1)]);
						endcase
						send_item(noise, $urandom);
						phase_items++;
					end
					send_item(base + SEQ_W'(order[k]), $urandom);
					phase_items++;
				end
				base = base + SEQ_W'(size);
			end
		end

		hold_until_drained();
		repeat (12) @(negedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### sim.f
hw/rtl/irb_pkg.sv
hw/rtl/irb_ctrl.sv
hw/rtl/irb_dp.sv
hw/rtl/in_order_release_buffer.sv
tb/irb_release_monitor.sv
tb/in_order_release_buffer_tb.sv
